/* rtl/core/fcsf_pkg.sv */
// ----------------------------------------------------------------------------
// fcsf_pkg
// Shared types and constants of the corner score filter: pixel and ring
// geometry, lane layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package fcsf_pkg;

    localparam int PIXEL_W      = 8;
    localparam int RING_POINTS  = 16;
    localparam int WORD_W       = 32;
    localparam int PIX_PER_LANE = WORD_W / PIXEL_W;
    localparam int LANES        = RING_POINTS / PIX_PER_LANE;
    localparam int LANE_SUM_W   = 10;
    localparam int SCORE_W      = 12;
    localparam int BARRIER_W    = 8;
    localparam int THRESH_W     = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BARRIER         = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 1'b1;

    localparam logic [BARRIER_W-1:0] BARRIER_RESET = 8'd20;
    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 12'd0;

    typedef struct packed {
        logic [PIXEL_W:0]   hi;
        logic [PIXEL_W-1:0] lo;
        logic               lo_ok;
    } band_t;

    typedef struct packed {
        logic [LANE_SUM_W-1:0] bright;
        logic [LANE_SUM_W-1:0] dark;
    } lane_sum_t;

endpackage

/* rtl/core/fast_corner_score_filter_unit.sv */
// ----------------------------------------------------------------------------
// fast_corner_score_filter_unit
// Corner score filter for the 16-point circle: four lanes score
// the ring words in parallel, a merge stage forms the score and keeps only
// corners above the threshold.
//
//   channel   dir   handshake               payload
//   s_axis    in    s_axis_tvalid/tready    candidate corner, 160-bit tdata
//   m_axis    out   m_axis_tvalid/tready    accepted corner, 40-bit tdata
//   cfg       in    cfg_we                  cfg_index, cfg_data
//
// Two register stages: lane sums, then the merge output register.
// One item per cycle while the output does not stall; each result passes the lane stage, then the merge register.
// Items below or at the threshold leave no result and no gap.
// A stalled output holds the merge register; an empty lane stage still takes
// one more item before s_axis_tready drops.
// Reset clears both valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
module fast_corner_score_filter_unit
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // center_pixel, ring_first, ring_second, ring_third, ring_fourth, column, line
    input  logic [(((fcsf_pkg::PIXEL_W + fcsf_pkg::LANES * fcsf_pkg::WORD_W
                     + 2 * COORD_BITS) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_column, out_line, score
    output logic [(((2 * COORD_BITS + fcsf_pkg::SCORE_W) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [fcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcsf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcsf_pkg::*;

    localparam int OUT_W      = 2 * COORD_BITS + SCORE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int RING_LO    = PIXEL_W;
    localparam int COL_LO     = PIXEL_W + LANES * WORD_W;
    localparam int LINE_LO    = COL_LO + COORD_BITS;

    logic [BARRIER_W-1:0]  barrier_reg;
    logic [THRESH_W-1:0]   threshold_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [COORD_BITS-1:0] column_reg;
    logic [COORD_BITS-1:0] line_reg;
    logic [PIXEL_W-1:0]    center;
    band_t                 band;
    logic                  in_xfer;
    logic                  merge_load;
    lane_sum_t             sums [LANES];
    logic [COORD_BITS-1:0] out_column;
    logic [COORD_BITS-1:0] out_line;
    logic [SCORE_W-1:0]    score;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            barrier_reg   <= BARRIER_RESET;
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BARRIER:         barrier_reg   <= cfg_data[BARRIER_W-1:0];
                REG_SCORE_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                default:             ;
            endcase
        end
    end

    assign center     = s_axis_tdata[PIXEL_W-1:0];
    assign band.hi    = {1'b0, center} + {1'b0, barrier_reg};
    assign band.lo    = center - barrier_reg;
    assign band.lo_ok = center >= barrier_reg;

    assign s_axis_tready = !s1_valid_reg || merge_load;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s1_valid_next = s_axis_tready ? in_xfer : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            column_reg <= s_axis_tdata[COL_LO +: COORD_BITS];
            line_reg   <= s_axis_tdata[LINE_LO +: COORD_BITS];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        fcsf_lane u_lane
        (
            .clk       (clk),
            .en        (in_xfer),
            .band      (band),
            .ring_word (s_axis_tdata[RING_LO + g*WORD_W +: WORD_W]),
            .sum       (sums[g])
        );
    end

    fcsf_merge
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .sums       (sums),
        .in_column  (column_reg),
        .in_line    (line_reg),
        .threshold  (threshold_reg),
        .out_ready  (m_axis_tready),
        .load       (merge_load),
        .out_valid  (m_axis_tvalid),
        .out_column (out_column),
        .out_line   (out_line),
        .score      (score)
    );

    assign m_axis_tdata = OUT_TDATA_W'({score, out_line, out_column});

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty lane stage");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_xfer_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted item lost before merge");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (score <= SCORE_W'(4080)))
        else $error("score out of range");

endmodule

/* rtl/core/fcsf_lane.sv */
// ----------------------------------------------------------------------------
// fcsf_lane
// One lane: scores the four ring pixels of one ring word against the
// intensity band and registers the partial bright and dark sums.
// ----------------------------------------------------------------------------
module fcsf_lane
(
    input  logic                      clk,
    input  logic                      en,
    input  fcsf_pkg::band_t           band,
    input  logic [fcsf_pkg::WORD_W-1:0] ring_word,
    output fcsf_pkg::lane_sum_t       sum
);
    import fcsf_pkg::*;

    lane_sum_t sum_reg;
    lane_sum_t sum_next;

    always_comb
    begin
        logic [PIXEL_W-1:0] p;
        logic [PIXEL_W:0]   excess;
        logic [PIXEL_W-1:0] shortfall;
        sum_next = '0;
        for (int k = 0; k < PIX_PER_LANE; k++)
        begin
            p         = ring_word[k*PIXEL_W +: PIXEL_W];
            excess    = {1'b0, p} - band.hi;
            shortfall = band.lo - p;
            if ({1'b0, p} > band.hi)
            begin
                sum_next.bright = sum_next.bright + LANE_SUM_W'(excess);
            end
            else if (band.lo_ok && (p < band.lo))
            begin
                sum_next.dark = sum_next.dark + LANE_SUM_W'(shortfall);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

/* rtl/core/fcsf_merge.sv */
// ----------------------------------------------------------------------------
// fcsf_merge
// Merge stage: adds the lane sums, picks the larger of bright and dark,
// tests it against the threshold and holds the result for transfer.
// ----------------------------------------------------------------------------
module fcsf_merge
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  fcsf_pkg::lane_sum_t           sums [fcsf_pkg::LANES],
    input  logic [COORD_BITS-1:0]         in_column,
    input  logic [COORD_BITS-1:0]         in_line,
    input  logic [fcsf_pkg::THRESH_W-1:0] threshold,
    input  logic                          out_ready,
    output logic                          load,
    output logic                          out_valid,
    output logic [COORD_BITS-1:0]         out_column,
    output logic [COORD_BITS-1:0]         out_line,
    output logic [fcsf_pkg::SCORE_W-1:0]  score
);
    import fcsf_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [COORD_BITS-1:0] column_reg;
    logic [COORD_BITS-1:0] line_reg;
    logic [SCORE_W-1:0]    score_reg;
    logic [SCORE_W-1:0]    bright_total;
    logic [SCORE_W-1:0]    dark_total;
    logic [SCORE_W-1:0]    best;
    logic                  pass;

    always_comb
    begin
        bright_total = '0;
        dark_total   = '0;
        for (int i = 0; i < LANES; i++)
        begin
            bright_total = bright_total + SCORE_W'(sums[i].bright);
            dark_total   = dark_total + SCORE_W'(sums[i].dark);
        end
        best = (bright_total > dark_total) ? bright_total : dark_total;
        pass = best > threshold;
    end

    assign load       = !valid_reg || out_ready;
    assign valid_next = load ? (in_valid && pass) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid && pass)
        begin
            column_reg <= in_column;
            line_reg   <= in_line;
            score_reg  <= best;
        end
    end

    assign out_valid  = valid_reg;
    assign out_column = column_reg;
    assign out_line   = line_reg;
    assign score      = score_reg;

endmodule

/* tb/fast_corner_score_filter_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fast_corner_score_filter_unit_tb
// Drives candidate corners into the score filter and checks every emitted
// corner against an in-bench score predictor. Directed corners cover the
// band edges, equal sums, the intensity limits and the threshold limits;
// random phases follow under random barrier and threshold settings, with
// random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module fast_corner_score_filter_unit_tb;

    import fcsf_pkg::*;

    localparam int COORD_W          = 12;
    localparam int IN_W             = (((PIXEL_W + LANES * WORD_W + 2 * COORD_W) + 7) / 8) * 8;
    localparam int OUT_W            = (((2 * COORD_W + SCORE_W) + 7) / 8) * 8;
    localparam int RES_W            = 2 * COORD_W + SCORE_W;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 8;

    // Field order from the lowest bit up: center, ring words 0..3, column, line.
    typedef struct packed {
        logic [COORD_W-1:0]              line;
        logic [COORD_W-1:0]              column;
        logic [LANES-1:0][WORD_W-1:0]    ring;
        logic [PIXEL_W-1:0]              center;
    } corner_t;

    // Field order from the lowest bit up: column, line, score.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] line;
        logic [COORD_W-1:0] column;
    } scored_corner_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // center_pixel, ring_first, ring_second, ring_third, ring_fourth, column, line
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_column, out_line, score
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [BARRIER_W-1:0]  barrier_q = BARRIER_RESET;
    logic [THRESH_W-1:0]   threshold_q = THRESH_RESET;

    scored_corner_t        pending_corners[$];
    int                    errors = 0;
    bit                    tx_idle_on = 1'b1;
    bit                    rx_idle_on = 1'b1;
    bit                    hold_output = 1'b0;

    fast_corner_score_filter_unit #(
        .COORD_BITS(COORD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("fast_corner_score_filter_unit verification failed");
        $finish;
    end

    function automatic bit score_corner(input corner_t c, output scored_corner_t r);
        int hi;
        int lo;
        int pix;
        int bright;
        int dark;
        int best;
        hi = int'(c.center) + int'(barrier_q);
        lo = int'(c.center) - int'(barrier_q);
        bright = 0;
        dark = 0;
        for (int k = 0; k < RING_POINTS; k++)
        begin
            pix = int'(c.ring[k / PIX_PER_LANE][(k % PIX_PER_LANE) * PIXEL_W +: PIXEL_W]);
            if (pix > hi)
                bright += pix - hi;
            else if (pix < lo)
                dark += lo - pix;
        end
        best = (bright > dark) ? bright : dark;
        r.column = c.column;
        r.line = c.line;
        r.score = best[SCORE_W-1:0];
        return best > int'(threshold_q);
    endfunction

    // Even ring points take pix_even, odd ones pix_odd.
    function automatic corner_t make_corner(input int center, input int pix_even,
                                            input int pix_odd, input int col, input int row);
        corner_t c;
        c.center = center[PIXEL_W-1:0];
        c.column = col[COORD_W-1:0];
        c.line = row[COORD_W-1:0];
        for (int k = 0; k < RING_POINTS; k++)
            c.ring[k / PIX_PER_LANE][(k % PIX_PER_LANE) * PIXEL_W +: PIXEL_W] =
                (k % 2 == 0) ? pix_even[PIXEL_W-1:0] : pix_odd[PIXEL_W-1:0];
        return c;
    endfunction

    function automatic int pick_pixel(input int center);
        int hi;
        int lo;
        int v;
        hi = center + int'(barrier_q);
        lo = center - int'(barrier_q);
        case ($urandom_range(0, 9))
            0: v = hi;
            1: v = hi + 1;
            2: v = lo;
            3: v = lo - 1;
            4: v = (hi < 255) ? $urandom_range(hi + 1, 255) : $urandom_range(0, 255);
            5: v = (lo > 0) ? $urandom_range(0, lo - 1) : $urandom_range(0, 255);
            6: v = 0;
            7: v = 255;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0 || v > 255)
            v = $urandom_range(0, 255);
        return v;
    endfunction

    function automatic corner_t random_corner();
        corner_t c;
        int center;
        case ($urandom_range(0, 5))
            0: center = 0;
            1: center = 255;
            default: center = $urandom_range(0, 255);
        endcase
        c.center = center[PIXEL_W-1:0];
        c.column = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        c.line = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        if ($urandom_range(0, 4) == 0)
        begin
            for (int w = 0; w < LANES; w++)
                c.ring[w] = $urandom();
        end
        else
        begin
            for (int k = 0; k < RING_POINTS; k++)
                c.ring[k / PIX_PER_LANE][(k % PIX_PER_LANE) * PIXEL_W +: PIXEL_W] =
                    PIXEL_W'(pick_pixel(center));
        end
        return c;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_corner(input corner_t c);
        bit taken;
        scored_corner_t r;
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            if (taken && score_corner(c, r))
                pending_corners.push_back(r);
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain_results();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_corners.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_corners.size() != 0)
        begin
            flag_mismatch("corners never delivered", 0, pending_corners.size());
            pending_corners.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BARRIER)
            barrier_q = data[BARRIER_W-1:0];
        else if (idx == REG_SCORE_THRESHOLD)
            threshold_q = data[THRESH_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin : rx_drive
        int stall;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 13);
                repeat (stall - 1) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        scored_corner_t got;
        scored_corner_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[RES_W-1:0];
            if (pending_corners.size() == 0)
            begin
                flag_mismatch("unexpected corner score", got.score, -1);
            end
            else
            begin
                want = pending_corners.pop_front();
                if (got.column != want.column)
                    flag_mismatch("column", got.column, want.column);
                if (got.line != want.line)
                    flag_mismatch("line", got.line, want.line);
                if (got.score != want.score)
                    flag_mismatch("score", got.score, want.score);
            end
        end
    end

    // Register reset values: barrier 20, threshold 0.
    task automatic test_reset_defaults();
        send_corner(make_corner(0, 0, 0, 0, 0));
        send_corner(make_corner(0, 255, 255, 4095, 0));
        send_corner(make_corner(255, 0, 0, 0, 4095));
        send_corner(make_corner(128, 148, 108, 4095, 4095));
        send_corner(make_corner(128, 149, 107, 1234, 2345));
        send_corner(make_corner(128, 149, 149, 2730, 1365));
        drain_results();
    endtask

    task automatic test_barrier_limits();
        // upper data bits must be dropped
        write_reg(REG_BARRIER, 12'hF00);
        send_corner(make_corner(0, 255, 255, 1, 2));
        send_corner(make_corner(255, 0, 0, 3, 4));
        send_corner(make_corner(77, 77, 77, 5, 6));
        send_corner(make_corner(77, 78, 76, 7, 8));
        drain_results();
        write_reg(REG_BARRIER, 12'd255);
        send_corner(make_corner(0, 255, 255, 9, 10));
        send_corner(make_corner(255, 0, 0, 11, 12));
        send_corner(make_corner(128, 0, 255, 13, 14));
        drain_results();
    endtask

    task automatic test_threshold_limits();
        write_reg(REG_BARRIER, 12'd0);
        write_reg(REG_SCORE_THRESHOLD, 12'd4095);
        send_corner(make_corner(0, 255, 255, 100, 200));
        drain_results();
        write_reg(REG_SCORE_THRESHOLD, 12'd4079);
        send_corner(make_corner(0, 255, 255, 101, 201));
        drain_results();
        write_reg(REG_SCORE_THRESHOLD, 12'd4080);
        send_corner(make_corner(255, 0, 0, 102, 202));
        drain_results();
        write_reg(REG_SCORE_THRESHOLD, 12'd16);
        send_corner(make_corner(100, 101, 101, 103, 203));
        send_corner(make_corner(100, 102, 102, 104, 204));
        drain_results();
    endtask

    task automatic test_backpressure();
        write_reg(REG_BARRIER, 12'd10);
        write_reg(REG_SCORE_THRESHOLD, 12'd0);
        tx_idle_on = 1'b0;
        hold_output = 1'b1;
        repeat (30)
            send_corner(make_corner(0, $urandom_range(11, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095)));
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 4))
            0: data[BARRIER_W-1:0] = '0;
            1: data[BARRIER_W-1:0] = '1;
            default: data[BARRIER_W-1:0] = BARRIER_W'($urandom_range(0, 80));
        endcase
        write_reg(REG_BARRIER, data);
        case ($urandom_range(0, 9))
            0: data = '0;
            1: data = '1;
            2: data = CFG_DATA_W'($urandom());
            default: data = CFG_DATA_W'($urandom_range(0, 300));
        endcase
        write_reg(REG_SCORE_THRESHOLD, data);
    endtask

    task automatic test_random_mix(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            random_settings();
            repeat (per_phase)
                send_corner(random_corner());
            drain_results();
        end
    endtask

    task automatic test_random_steady(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_settings();
        repeat (count)
            send_corner(random_corner());
        drain_results();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_barrier_limits();
        test_threshold_limits();
        test_backpressure();
        test_random_mix(6, 70);
        test_random_steady(60);
        if (errors == 0)
            $display("fast_corner_score_filter_unit verification clean");
        else
            $display("fast_corner_score_filter_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/fcsf_pkg.sv
rtl/core/fcsf_lane.sv
rtl/core/fcsf_merge.sv
rtl/core/fast_corner_score_filter_unit.sv
tb/fast_corner_score_filter_unit_tb.sv
